// ===== design/pavr_pkg.sv =====
// ----------------------------------------------------------------------------
// pavr_pkg
// shared types, constants and helpers of the principal-axis vertex rotation
// ----------------------------------------------------------------------------
package pavr_pkg;

   // fixed formats
   localparam int TRIG_BITS       = 18;
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int TRIG_FRAC       = TRIG_BITS - 2;

   localparam int COORD_W   = 32;
   localparam int ANGLE_W   = 16;
   localparam int MASK_W    = 3;
   localparam int AXIS_W    = 2;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MASK  = CSR_IDX_W'(1);

   typedef enum logic [AXIS_W-1:0] {
      AXIS_NONE = 2'd0,
      AXIS_X    = 2'd1,
      AXIS_Y    = 2'd2,
      AXIS_Z    = 2'd3
   } axis_type;

   // angle reduction
   localparam int FULL_TURN    = 360 << ANGLE_FRAC_BITS;
   localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
   localparam int EIGHTH_TURN  = 45 << ANGLE_FRAC_BITS;
   localparam int ANG_W = ((ANGLE_W > $clog2(FULL_TURN)) ? ANGLE_W : $clog2(FULL_TURN)) + 2;
   localparam logic signed [ANG_W-1:0] FULL_ANG    = ANG_W'(FULL_TURN);
   localparam logic signed [ANG_W-1:0] QUARTER_ANG = ANG_W'(QUARTER_TURN);
   localparam logic signed [ANG_W-1:0] EIGHTH_ANG  = ANG_W'(EIGHTH_TURN);

   // Q30 series evaluation
   localparam int Q_FRAC  = 30;
   localparam int Q_W     = Q_FRAC + 1;
   localparam int DEG_W   = 25;
   localparam logic [DEG_W-1:0] DEG_TO_RAD = 25'd18740330;
   localparam logic [Q_W-1:0]   Q_ONE      = Q_W'(1) << Q_FRAC;
   localparam int DIV_W     = 8;
   localparam int STEP_W    = 3;
   localparam int SIN_TERMS = 5;
   localparam int COS_TERMS = 6;
   localparam int RECIP_SH  = 31;

   // rotation datapath
   localparam int PROD_W = COORD_W + TRIG_BITS;
   localparam int SUM_W  = PROD_W + 1;
   localparam int SH_W   = SUM_W - TRIG_FRAC;

   typedef struct packed {
      logic                        busy;
      logic signed [TRIG_BITS-1:0] sine;
      logic signed [TRIG_BITS-1:0] cosine;
   } trig_status_type;

   typedef enum logic [3:0] {
      TRIG_IDLE,
      TRIG_WRAP,
      TRIG_QUAD,
      TRIG_RAD,
      TRIG_SQUARE,
      TRIG_HMUL,
      TRIG_HDIV,
      TRIG_HFIX,
      TRIG_SMUL,
      TRIG_DONE
   } trig_state_type;

   // divisors of the horner chains, sine chain first
   function automatic logic [DIV_W-1:0] horner_div(input logic cos_chain,
                                                   input logic [STEP_W-1:0] step);
      logic [DIV_W-1:0] d;
      d = DIV_W'(1);
      if (!cos_chain) begin
         case (step)
            3'd0: d = 8'd110;
            3'd1: d = 8'd72;
            3'd2: d = 8'd42;
            3'd3: d = 8'd20;
            3'd4: d = 8'd6;
            default: d = 8'd6;
         endcase
      end else begin
         case (step)
            3'd0: d = 8'd132;
            3'd1: d = 8'd90;
            3'd2: d = 8'd56;
            3'd3: d = 8'd30;
            3'd4: d = 8'd12;
            3'd5: d = 8'd2;
            default: d = 8'd2;
         endcase
      end
      return d;
   endfunction

   // floor(2^31 / divisor) for the same steps
   function automatic logic [Q_W-1:0] horner_recip(input logic cos_chain,
                                                   input logic [STEP_W-1:0] step);
      logic [Q_W-1:0] r;
      r = 31'd1073741824;
      if (!cos_chain) begin
         case (step)
            3'd0: r = 31'd19522578;
            3'd1: r = 31'd29826161;
            3'd2: r = 31'd51130563;
            3'd3: r = 31'd107374182;
            3'd4: r = 31'd357913941;
            default: r = 31'd357913941;
         endcase
      end else begin
         case (step)
            3'd0: r = 31'd16268815;
            3'd1: r = 31'd23860929;
            3'd2: r = 31'd38347922;
            3'd3: r = 31'd71582788;
            3'd4: r = 31'd178956970;
            3'd5: r = 31'd1073741824;
            default: r = 31'd1073741824;
         endcase
      end
      return r;
   endfunction

endpackage

// ===== design/pavr_chan_if.sv =====
// ----------------------------------------------------------------------------
// pavr channel interfaces
// vertex request, rotated result and register write channels
// ----------------------------------------------------------------------------
interface pavr_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [pavr_pkg::COORD_W-1:0] pos_x;
   logic signed [pavr_pkg::COORD_W-1:0] pos_y;
   logic signed [pavr_pkg::COORD_W-1:0] pos_z;

   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface pavr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pavr_pkg::COORD_W-1:0] rot_x;
   logic signed [pavr_pkg::COORD_W-1:0] rot_y;
   logic signed [pavr_pkg::COORD_W-1:0] rot_z;
   logic [pavr_pkg::AXIS_W-1:0]         axis_used;
   logic                                last_of_vertex;

   modport source (output valid, output rot_x, output rot_y, output rot_z,
                   output axis_used, output last_of_vertex, input ready);
   modport sink   (input valid, input rot_x, input rot_y, input rot_z,
                   input axis_used, input last_of_vertex, output ready);
endinterface

interface pavr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pavr_pkg::CSR_IDX_W-1:0]    wr_index;
   logic [pavr_pkg::ANGLE_W-1:0]      wr_data;

   modport source (output valid, output wr_index, output wr_data, input ready);
   modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

// ===== design/principal_axis_vertex_rotation.sv =====
// ----------------------------------------------------------------------------
// principal_axis_vertex_rotation
// rotates each vertex about every selected principal axis, X then Y then Z
// ----------------------------------------------------------------------------
//  channel  | direction | word
//  ---------+-----------+-----------------------------------------------------
//  req_bus  | in        | pos_x, pos_y, pos_z
//  rsp_bus  | out       | rot_x, rot_y, rot_z, axis_used, last_of_vertex
//  csr_bus  | in        | wr_index (0 angle, 1 axis mask), wr_data
//
//  a vertex holds the input stage until its last result moves on: 1 to 3
//  results; one result leaves per cycle while the output is not stalled; the
//  first result passes the multiply, sum and round, and saturate stages into
//  the output register. an angle write starts the sine/cosine sequencer
//  (11 series terms of a multiply, a reciprocal multiply and a correction);
//  vertices are held off until it finishes. reset is synchronous, active high.
//  every stage has its own valid and advances when the next has room.
// ----------------------------------------------------------------------------
module principal_axis_vertex_rotation (
   input  logic        clock,
   input  logic        reset,
   pavr_req_if.sink    req_bus,
   pavr_rsp_if.source  rsp_bus,
   pavr_csr_if.sink    csr_bus
);
   import pavr_pkg::*;

   localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(2147483647);
   localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-2147483647 - 1);

   // configuration
   logic signed [ANGLE_W-1:0] angle_ff;
   logic [MASK_W-1:0]         mask_ff;
   logic                      csr_fire;
   logic                      trig_start;
   trig_status_type           trig;

   // hold stage
   logic                      e_valid_ff;
   logic [MASK_W-1:0]         e_pend_ff;
   logic signed [COORD_W-1:0] e_x_ff, e_y_ff, e_z_ff;
   axis_type                  job_axis;
   logic                      job_last;
   logic                      e_fire;
   logic                      req_fire;

   // multiply stage
   logic                      m_valid_ff;
   logic                      m_ready;
   axis_type                  m_axis_ff;
   logic                      m_last_ff;
   logic signed [COORD_W-1:0] m_x_ff, m_y_ff, m_z_ff;
   logic signed [PROD_W-1:0]  m_uc_ff, m_vs_ff, m_us_ff, m_vc_ff;
   logic signed [COORD_W-1:0] op_u, op_v;
   logic signed [PROD_W-1:0]  m_uc_in, m_vs_in, m_us_in, m_vc_in;

   // sum stage
   logic                      a_valid_ff;
   logic                      a_ready;
   axis_type                  a_axis_ff;
   logic                      a_last_ff;
   logic signed [COORD_W-1:0] a_x_ff, a_y_ff, a_z_ff;
   logic signed [SH_W-1:0]    a_first_ff, a_second_ff;
   logic signed [SUM_W-1:0]   sum_first, sum_second;
   logic signed [SH_W-1:0]    a_first_in, a_second_in;

   // output stage
   logic                      o_ready;
   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic signed [COORD_W-1:0] rsp_x_in, rsp_y_in, rsp_z_in;
   logic signed [COORD_W-1:0] sat_first, sat_second;
   axis_type                  rsp_axis_ff;
   logic                      rsp_last_ff;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SH_W-1:0] v);
      logic signed [SH_W-1:0] r;
      r = v;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end
      return r[COORD_W-1:0];
   endfunction

   // ---------------------------------------------------------------- config
   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;
   assign trig_start    = csr_fire && (csr_bus.wr_index == CSR_ANGLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         mask_ff  <= '0;
      end else if (csr_fire) begin
         if (csr_bus.wr_index == CSR_ANGLE) begin
            angle_ff <= signed'(csr_bus.wr_data);
         end else if (csr_bus.wr_index == CSR_MASK) begin
            mask_ff <= csr_bus.wr_data[MASK_W-1:0];
         end
      end
   end

   pavr_trig u_trig (
      .clock  (clock),
      .reset  (reset),
      .start  (trig_start),
      .angle  (signed'(csr_bus.wr_data)),
      .status (trig)
   );

   // ---------------------------------------------------------------- hold
   // an empty pending mask on a valid vertex means pass-through
   always_comb begin
      if (e_pend_ff[0]) begin
         job_axis = AXIS_X;
      end else if (e_pend_ff[1]) begin
         job_axis = AXIS_Y;
      end else if (e_pend_ff[2]) begin
         job_axis = AXIS_Z;
      end else begin
         job_axis = AXIS_NONE;
      end
   end

   assign job_last      = ((e_pend_ff & (e_pend_ff - MASK_W'(1))) == '0);
   assign e_fire        = e_valid_ff && m_ready;
   assign req_bus.ready = !trig.busy && (!e_valid_ff || (m_ready && job_last));
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (req_fire) begin
         e_valid_ff <= 1'b1;
      end else if (e_fire && job_last) begin
         e_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         e_pend_ff <= (angle_ff == '0) ? '0 : mask_ff;
         e_x_ff    <= req_bus.pos_x;
         e_y_ff    <= req_bus.pos_y;
         e_z_ff    <= req_bus.pos_z;
      end else if (e_fire) begin
         e_pend_ff <= e_pend_ff & (e_pend_ff - MASK_W'(1));
      end
   end

   // ---------------------------------------------------------------- multiply
   // u is the lower of the two rotated coordinates, v the higher
   assign op_u    = (job_axis == AXIS_X) ? e_y_ff : e_x_ff;
   assign op_v    = (job_axis == AXIS_Z) ? e_y_ff : e_z_ff;
   assign m_uc_in = PROD_W'(op_u) * PROD_W'(trig.cosine);
   assign m_vs_in = PROD_W'(op_v) * PROD_W'(trig.sine);
   assign m_us_in = PROD_W'(op_u) * PROD_W'(trig.sine);
   assign m_vc_in = PROD_W'(op_v) * PROD_W'(trig.cosine);
   assign m_ready = !m_valid_ff || a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (m_ready) begin
         m_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (e_fire) begin
         m_axis_ff <= job_axis;
         m_last_ff <= job_last;
         m_x_ff    <= e_x_ff;
         m_y_ff    <= e_y_ff;
         m_z_ff    <= e_z_ff;
         m_uc_ff   <= m_uc_in;
         m_vs_ff   <= m_vs_in;
         m_us_ff   <= m_us_in;
         m_vc_ff   <= m_vc_in;
      end
   end

   // ---------------------------------------------------------------- sum, round
   // about Y the sine terms swap sign; the arithmetic shift rounds half up
   always_comb begin
      if (m_axis_ff == AXIS_Y) begin
         sum_first  = SUM_W'(m_uc_ff) + SUM_W'(m_vs_ff);
         sum_second = SUM_W'(m_vc_ff) - SUM_W'(m_us_ff);
      end else begin
         sum_first  = SUM_W'(m_uc_ff) - SUM_W'(m_vs_ff);
         sum_second = SUM_W'(m_vc_ff) + SUM_W'(m_us_ff);
      end
      a_first_in  = SH_W'((sum_first + (SUM_W'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC);
      a_second_in = SH_W'((sum_second + (SUM_W'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC);
   end

   assign a_ready = !a_valid_ff || o_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && m_valid_ff) begin
         a_axis_ff   <= m_axis_ff;
         a_last_ff   <= m_last_ff;
         a_x_ff      <= m_x_ff;
         a_y_ff      <= m_y_ff;
         a_z_ff      <= m_z_ff;
         a_first_ff  <= a_first_in;
         a_second_ff <= a_second_in;
      end
   end

   // ---------------------------------------------------------------- saturate
   assign sat_first  = sat_coord(a_first_ff);
   assign sat_second = sat_coord(a_second_ff);
   assign o_ready    = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_x_in = a_x_ff;
      rsp_y_in = a_y_ff;
      rsp_z_in = a_z_ff;
      case (a_axis_ff)
         AXIS_X: begin
            rsp_y_in = sat_first;
            rsp_z_in = sat_second;
         end
         AXIS_Y: begin
            rsp_x_in = sat_first;
            rsp_z_in = sat_second;
         end
         AXIS_Z: begin
            rsp_x_in = sat_first;
            rsp_y_in = sat_second;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (o_ready) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_ready && a_valid_ff) begin
         rsp_x_ff    <= rsp_x_in;
         rsp_y_ff    <= rsp_y_in;
         rsp_z_ff    <= rsp_z_in;
         rsp_axis_ff <= a_axis_ff;
         rsp_last_ff <= a_last_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.rot_x          = rsp_x_ff;
   assign rsp_bus.rot_y          = rsp_y_ff;
   assign rsp_bus.rot_z          = rsp_z_ff;
   assign rsp_bus.axis_used      = rsp_axis_ff;
   assign rsp_bus.last_of_vertex = rsp_last_ff;

endmodule

// ===== design/pavr_trig.sv =====
// ----------------------------------------------------------------------------
// pavr_trig
// sequential sine/cosine of the configured angle, one shared multiplier for
// the series terms and their reciprocal divisions
// ----------------------------------------------------------------------------
module pavr_trig (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [pavr_pkg::ANGLE_W-1:0] angle,
   output pavr_pkg::trig_status_type           status
);
   import pavr_pkg::*;

   localparam int RAD_PW = ANG_W - 1 + DEG_W;
   localparam int RND    = 1 << (Q_FRAC - 1 - TRIG_FRAC);
   localparam int ONE_T  = 1 << TRIG_FRAC;

   trig_state_type state_ff, state_in;

   logic signed [ANG_W-1:0]     ang_ff, ang_in;
   logic [1:0]                  quad_ff, quad_in;
   logic                        swap_ff, swap_in;
   logic [Q_W-1:0]              x_ff, x_in;
   logic [Q_W-1:0]              x2_ff, x2_in;
   logic [Q_W-1:0]              t_ff, t_in;
   logic [Q_W-1:0]              sq_ff, sq_in;
   logic [Q_W-1:0]              quo_ff, quo_in;
   logic [Q_W-1:0]              qe_ff, qe_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic                        chain_ff, chain_in;
   logic signed [TRIG_BITS-1:0] sine_ff, sine_in;
   logic signed [TRIG_BITS-1:0] cos_ff, cos_in;

   logic [RAD_PW-1:0]  rad_prod;
   logic [Q_W-1:0]     mul_a;
   logic [Q_W-1:0]     mul_b;
   logic [2*Q_W-1:0]   mul_prod;
   logic [DIV_W-1:0]   divisor;
   logic [Q_W-1:0]     recip;
   logic [Q_W-1:0]     quo_rem;
   logic [Q_W-1:0]     quo_fix;
   logic               last_step;
   logic [Q_W-1:0]     s_q30;
   logic [Q_W-1:0]     c_q30;
   logic signed [TRIG_BITS-1:0] s_mag;
   logic signed [TRIG_BITS-1:0] c_mag;

   function automatic logic [TRIG_FRAC:0] q30_round(input logic [Q_W-1:0] v);
      logic [Q_W:0] r;
      r = ({1'b0, v} + (Q_W + 1)'(RND)) >> (Q_FRAC - TRIG_FRAC);
      if (r > (Q_W + 1)'(ONE_T)) begin
         r = (Q_W + 1)'(ONE_T);
      end
      return r[TRIG_FRAC:0];
   endfunction

   assign rad_prod = RAD_PW'(ang_ff[ANG_W-2:0]) * RAD_PW'(DEG_TO_RAD);

   // one multiplier shared by the squaring, horner, reciprocal and sine steps
   always_comb begin
      case (state_ff)
         TRIG_SQUARE: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         TRIG_SMUL: begin
            mul_a = x_ff;
            mul_b = t_ff;
         end
         TRIG_HDIV: begin
            mul_a = quo_ff;
            mul_b = recip;
         end
         default: begin
            mul_a = x2_ff;
            mul_b = t_ff;
         end
      endcase
   end

   assign mul_prod  = (2 * Q_W)'(mul_a) * (2 * Q_W)'(mul_b);
   assign divisor   = horner_div(chain_ff, step_ff);
   assign recip     = horner_recip(chain_ff, step_ff);
   // the reciprocal estimate is low by at most one
   assign quo_rem   = quo_ff - Q_W'(qe_ff * Q_W'(divisor));
   assign quo_fix   = (quo_rem >= Q_W'(divisor)) ? qe_ff + Q_W'(1) : qe_ff;
   assign last_step = chain_ff ? (step_ff == STEP_W'(COS_TERMS - 1))
                               : (step_ff == STEP_W'(SIN_TERMS - 1));

   // past 45 degrees the chains ran on the complement, so sine and cosine swap
   assign s_q30 = swap_ff ? t_ff : sq_ff;
   assign c_q30 = swap_ff ? sq_ff : t_ff;
   assign s_mag = signed'({1'b0, q30_round(s_q30)});
   assign c_mag = signed'({1'b0, q30_round(c_q30)});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TRIG_IDLE;
         sine_ff  <= '0;
         cos_ff   <= TRIG_BITS'(ONE_T);
      end else begin
         state_ff <= state_in;
         sine_ff  <= sine_in;
         cos_ff   <= cos_in;
      end
   end

   always_ff @(posedge clock) begin
      ang_ff   <= ang_in;
      quad_ff  <= quad_in;
      swap_ff  <= swap_in;
      x_ff     <= x_in;
      x2_ff    <= x2_in;
      t_ff     <= t_in;
      sq_ff    <= sq_in;
      quo_ff   <= quo_in;
      qe_ff    <= qe_in;
      step_ff  <= step_in;
      chain_ff <= chain_in;
   end

   always_comb begin
      state_in = state_ff;
      ang_in   = ang_ff;
      quad_in  = quad_ff;
      swap_in  = swap_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      t_in     = t_ff;
      sq_in    = sq_ff;
      quo_in   = quo_ff;
      qe_in    = qe_ff;
      step_in  = step_ff;
      chain_in = chain_ff;
      sine_in  = sine_ff;
      cos_in   = cos_ff;
      case (state_ff)
         TRIG_IDLE: begin
         end
         TRIG_WRAP: begin
            if (ang_ff < 0) begin
               ang_in = ang_ff + FULL_ANG;
            end else if (ang_ff >= FULL_ANG) begin
               ang_in = ang_ff - FULL_ANG;
            end else begin
               quad_in  = 2'd0;
               state_in = TRIG_QUAD;
            end
         end
         TRIG_QUAD: begin
            if (ang_ff >= QUARTER_ANG) begin
               ang_in  = ang_ff - QUARTER_ANG;
               quad_in = quad_ff + 2'd1;
            end else begin
               if (ang_ff > EIGHTH_ANG) begin
                  ang_in  = QUARTER_ANG - ang_ff;
                  swap_in = 1'b1;
               end else begin
                  swap_in = 1'b0;
               end
               state_in = TRIG_RAD;
            end
         end
         TRIG_RAD: begin
            x_in     = rad_prod[ANGLE_FRAC_BITS +: Q_W];
            state_in = TRIG_SQUARE;
         end
         TRIG_SQUARE: begin
            x2_in    = mul_prod[Q_FRAC +: Q_W];
            t_in     = Q_ONE;
            step_in  = '0;
            chain_in = 1'b0;
            state_in = TRIG_HMUL;
         end
         TRIG_HMUL: begin
            quo_in   = mul_prod[Q_FRAC +: Q_W];
            state_in = TRIG_HDIV;
         end
         TRIG_HDIV: begin
            qe_in    = mul_prod[RECIP_SH +: Q_W];
            state_in = TRIG_HFIX;
         end
         TRIG_HFIX: begin
            t_in    = Q_ONE - quo_fix;
            step_in = step_ff + STEP_W'(1);
            if (!last_step) begin
               state_in = TRIG_HMUL;
            end else if (chain_ff) begin
               state_in = TRIG_DONE;
            end else begin
               state_in = TRIG_SMUL;
            end
         end
         TRIG_SMUL: begin
            sq_in    = mul_prod[Q_FRAC +: Q_W];
            t_in     = Q_ONE;
            step_in  = '0;
            chain_in = 1'b1;
            state_in = TRIG_HMUL;
         end
         TRIG_DONE: begin
            case (quad_ff)
               2'd0: begin
                  sine_in = s_mag;
                  cos_in  = c_mag;
               end
               2'd1: begin
                  sine_in = c_mag;
                  cos_in  = -s_mag;
               end
               2'd2: begin
                  sine_in = -s_mag;
                  cos_in  = -c_mag;
               end
               default: begin
                  sine_in = -c_mag;
                  cos_in  = s_mag;
               end
            endcase
            state_in = TRIG_IDLE;
         end
         default: begin
            state_in = TRIG_IDLE;
         end
      endcase
      if (start) begin
         ang_in   = ANG_W'(angle);
         state_in = TRIG_WRAP;
      end
   end

   assign status.busy   = (state_ff != TRIG_IDLE);
   assign status.sine   = sine_ff;
   assign status.cosine = cos_ff;

endmodule

// ===== design/pavr_checker.sv =====
// ----------------------------------------------------------------------------
// pavr_checker
// port-level checks of the vertex rotation block
// ----------------------------------------------------------------------------
module pavr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [pavr_pkg::AXIS_W-1:0]    rsp_axis,
   input logic                           rsp_last,
   input logic signed [pavr_pkg::COORD_W-1:0] rsp_rot_x,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [pavr_pkg::CSR_IDX_W-1:0] csr_index
);
   import pavr_pkg::*;

   // a pass-through word is always the only one of its vertex
   a_pass_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_axis == AXIS_NONE) |-> rsp_last)
      else $error("pass-through word without last_of_vertex");

   // a new angle holds off vertices while sine and cosine are rederived
   a_angle_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == CSR_ANGLE) |=> !req_ready)
      else $error("vertex accepted right after an angle write");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rot_x))
      else $error("stalled result word changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind principal_axis_vertex_rotation pavr_checker u_pavr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_axis  (rsp_bus.axis_used),
   .rsp_last  (rsp_bus.last_of_vertex),
   .rsp_rot_x (rsp_bus.rot_x),
   .csr_valid (csr_bus.valid),
   .csr_ready (csr_bus.ready),
   .csr_index (csr_bus.wr_index)
);
